// ----- sv/ufh_pkg.sv -----
// Shared types and constants for the weighted union-find engine.
package ufh_pkg;

    localparam int MAX_NODES = 1024;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int SIZE_W    = NODE_W + 1;
    localparam int REQ_W     = 32;

    localparam logic [SIZE_W-1:0] NODE_COUNT_RST = SIZE_W'(MAX_NODES);
    localparam logic [SIZE_W-1:0] NODE_COUNT_MIN = SIZE_W'(2);

    typedef struct packed {
        logic [NODE_W-1:0] first;
        logic [NODE_W-1:0] second;
        logic              bad;
    } t_req;

    typedef struct packed {
        logic [NODE_W-1:0] first_root;
        logic [NODE_W-1:0] second_root;
        logic              already_joined;
        logic [NODE_W-1:0] new_root;
        logic [SIZE_W-1:0] merged_size;
        logic [NODE_W-1:0] union_total;
        logic [REQ_W-1:0]  request_total;
        logic              all_joined;
        logic              bad_index;
    } t_result;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_GOT_P,
        BK_GOT_GP,
        BK_SZ_A,
        BK_LINK
    } t_bk_state;

endpackage

// ----- sv/ufh_front.sv -----
// Front end: range check of incoming requests and a two-entry request queue.
module ufh_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  logic [ufh_pkg::NODE_W-1:0]  i_first,
    input  logic [ufh_pkg::NODE_W-1:0]  i_second,
    input  logic [ufh_pkg::SIZE_W-1:0]  i_eff_count,
    input  logic                        i_pop,
    output logic                        o_full,
    output logic                        o_valid,
    output ufh_pkg::t_req               o_head
);
    import ufh_pkg::*;

    t_req       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_req       w_in;

    always_comb begin
        w_in.first  = i_first;
        w_in.second = i_second;
        w_in.bad    = ({1'b0, i_first} >= i_eff_count) || ({1'b0, i_second} >= i_eff_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= w_in;
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_head  = r_q[r_rp];

endmodule

// ----- sv/ufh_back.sv -----
// Back end: clearing pass, root walks with path halving, linking and result register.
module ufh_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  ufh_pkg::t_req               i_head,
    input  logic [ufh_pkg::SIZE_W-1:0]  i_eff_count,
    output logic                        o_pop,
    output logic                        o_clearing,
    output logic                        o_done,
    output ufh_pkg::t_result            o_res
);
    import ufh_pkg::*;

    logic [NODE_W-1:0] parent_mem [MAX_NODES];
    logic [SIZE_W-1:0] size_mem   [MAX_NODES];

    t_bk_state         r_state, n_state;
    logic [NODE_W-1:0] r_x, n_x, r_ra, n_ra, r_rb, n_rb;
    logic [SIZE_W-1:0] r_sa, n_sa;
    logic              r_phase, n_phase;
    logic [NODE_W-1:0] r_ucnt, n_ucnt;
    logic [REQ_W-1:0]  r_rcnt, n_rcnt;
    logic              r_clearing;
    logic [NODE_W-1:0] r_clr;
    logic              r_done, n_done;
    t_result           r_res, n_res;

    logic [NODE_W-1:0] r_prd;
    logic [SIZE_W-1:0] r_srd;
    logic [NODE_W-1:0] p_raddr, p_waddr, p_wdata;
    logic [NODE_W-1:0] s_raddr, s_waddr;
    logic [SIZE_W-1:0] s_wdata, w_sum;
    logic              p_we, s_we;

    assign w_sum = r_sa + r_srd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= BK_IDLE;
            r_ucnt     <= '0;
            r_rcnt     <= '0;
            r_clearing <= 1'b1;
            r_clr      <= '0;
            r_done     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ucnt  <= n_ucnt;
            r_rcnt  <= n_rcnt;
            r_done  <= n_done;
            if (r_clearing) begin
                r_clr <= r_clr + 1'b1;
                if (r_clr == NODE_W'(MAX_NODES - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x     <= n_x;
        r_ra    <= n_ra;
        r_rb    <= n_rb;
        r_sa    <= n_sa;
        r_phase <= n_phase;
        r_res   <= n_res;
    end

    // Table storage; the clearing pass owns the write ports after reset.
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            parent_mem[r_clr] <= r_clr;
            size_mem[r_clr]   <= SIZE_W'(1);
        end else begin
            if (p_we) begin
                parent_mem[p_waddr] <= p_wdata;
            end
            if (s_we) begin
                size_mem[s_waddr] <= s_wdata;
            end
        end
        r_prd <= parent_mem[p_raddr];
        r_srd <= size_mem[s_raddr];
    end

    always_comb begin
        n_state = r_state;
        n_x     = r_x;
        n_ra    = r_ra;
        n_rb    = r_rb;
        n_sa    = r_sa;
        n_phase = r_phase;
        n_ucnt  = r_ucnt;
        n_rcnt  = r_rcnt;
        n_done  = 1'b0;
        n_res   = r_res;
        o_pop   = 1'b0;
        p_raddr = r_x;
        s_raddr = r_ra;
        p_we    = 1'b0;
        p_waddr = r_x;
        p_wdata = r_prd;
        s_we    = 1'b0;
        s_waddr = r_ra;
        s_wdata = w_sum;
        case (r_state)
            BK_IDLE: begin
                if (!r_clearing && i_valid) begin
                    o_pop = 1'b1;
                    if (r_rcnt != '1) begin
                        n_rcnt = r_rcnt + 1'b1;
                    end
                    if (i_head.bad) begin
                        n_done               = 1'b1;
                        n_res                = '0;
                        n_res.bad_index      = 1'b1;
                        n_res.union_total    = r_ucnt;
                        n_res.request_total  = n_rcnt;
                        n_res.all_joined     = ({1'b0, r_ucnt} >= i_eff_count - 1'b1);
                    end else begin
                        n_x     = i_head.first;
                        n_rb    = i_head.second;
                        n_phase = 1'b0;
                        p_raddr = i_head.first;
                        n_state = BK_GOT_P;
                    end
                end
            end
            BK_GOT_P: begin
                if (r_prd == r_x) begin
                    if (!r_phase) begin
                        n_ra    = r_x;
                        n_phase = 1'b1;
                        n_x     = r_rb;
                        p_raddr = r_rb;
                    end else begin
                        n_rb    = r_x;
                        s_raddr = r_ra;
                        n_state = BK_SZ_A;
                    end
                end else begin
                    p_raddr = r_prd;
                    n_state = BK_GOT_GP;
                end
            end
            BK_GOT_GP: begin
                // halve: point x at its grandparent and continue from there
                p_we    = 1'b1;
                p_waddr = r_x;
                p_wdata = r_prd;
                n_x     = r_prd;
                p_raddr = r_prd;
                n_state = BK_GOT_P;
            end
            BK_SZ_A: begin
                n_sa    = r_srd;
                s_raddr = r_rb;
                n_state = BK_LINK;
            end
            BK_LINK: begin
                n_done              = 1'b1;
                n_res.first_root    = r_ra;
                n_res.second_root   = r_rb;
                n_res.bad_index     = 1'b0;
                n_res.request_total = r_rcnt;
                if (r_ra == r_rb) begin
                    n_res.already_joined = 1'b1;
                    n_res.new_root       = r_ra;
                    n_res.merged_size    = r_sa;
                end else begin
                    n_res.already_joined = 1'b0;
                    n_res.merged_size    = w_sum;
                    n_ucnt               = r_ucnt + 1'b1;
                    p_we                 = 1'b1;
                    s_we                 = 1'b1;
                    if (r_sa < r_srd) begin
                        p_waddr        = r_ra;
                        p_wdata        = r_rb;
                        s_waddr        = r_rb;
                        n_res.new_root = r_rb;
                    end else begin
                        p_waddr        = r_rb;
                        p_wdata        = r_ra;
                        s_waddr        = r_ra;
                        n_res.new_root = r_ra;
                    end
                end
                n_res.union_total = n_ucnt;
                n_res.all_joined  = ({1'b0, n_ucnt} >= i_eff_count - 1'b1);
                n_state           = BK_IDLE;
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    assign o_clearing = r_clearing;
    assign o_done     = r_done;
    assign o_res      = r_res;

    a_no_done_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !r_done) else $error("result during clearing pass");
    a_joined_not_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !(r_res.already_joined && r_res.bad_index))
        else $error("joined and bad both set");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == BK_IDLE) && i_valid) else $error("pop outside idle");
    a_ucnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ucnt != $past(r_ucnt)) |-> ($past(r_state) == BK_LINK))
        else $error("union count moved outside link");

endmodule

// ----- sv/union_find_weighted_halving.sv -----
// Top level of the weighted union-find engine with path halving.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+---------------------------------------
//  request   | start (in), busy (out)    | i_first_node, i_second_node
//  result    | o_done (one-cycle strobe) | o_first_root .. o_bad_index
//  config    | i_cfg_we                  | i_cfg_wdata (node_count)
//
// A request is taken when start is high and busy is low; it enters a two-entry
// queue, so up to two requests may wait while the back end works.
// Each request makes two root walks by halving steps through the single read port of
// the parent table; a ten-level tree needs five steps per walk. The o_done strobe
// follows in the cycle after the link step, the last back-end step of a request.
// An out-of-range request leaves the tables alone.
// After reset a clearing pass rebuilds the tables; busy is high while it runs.
// The receiver cannot stall: o_done is high for exactly one cycle per request.
module union_find_weighted_halving (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [ufh_pkg::NODE_W-1:0]  i_first_node,
    input  logic [ufh_pkg::NODE_W-1:0]  i_second_node,
    input  logic                        i_cfg_we,
    input  logic [ufh_pkg::SIZE_W-1:0]  i_cfg_wdata,
    output logic                        o_done,
    output logic [ufh_pkg::NODE_W-1:0]  o_first_root,
    output logic [ufh_pkg::NODE_W-1:0]  o_second_root,
    output logic                        o_already_joined,
    output logic [ufh_pkg::NODE_W-1:0]  o_new_root,
    output logic [ufh_pkg::SIZE_W-1:0]  o_merged_size,
    output logic [ufh_pkg::NODE_W-1:0]  o_union_total,
    output logic [ufh_pkg::REQ_W-1:0]   o_request_total,
    output logic                        o_all_joined,
    output logic                        o_bad_index
);
    import ufh_pkg::*;

    logic [SIZE_W-1:0] r_node_count;
    logic [SIZE_W-1:0] w_eff;
    logic              w_full, w_valid, w_pop, w_clearing, w_push;
    t_req              w_head;
    t_result           w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_COUNT_RST;
        end else if (i_cfg_we) begin
            r_node_count <= i_cfg_wdata;
        end
    end

    // clamp the node count into the legal range
    always_comb begin
        if (r_node_count < NODE_COUNT_MIN) begin
            w_eff = NODE_COUNT_MIN;
        end else if (r_node_count > SIZE_W'(MAX_NODES)) begin
            w_eff = SIZE_W'(MAX_NODES);
        end else begin
            w_eff = r_node_count;
        end
    end

    assign busy   = w_full || w_clearing;
    assign w_push = start && !busy;

    ufh_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_first     (i_first_node),
        .i_second    (i_second_node),
        .i_eff_count (w_eff),
        .i_pop       (w_pop),
        .o_full      (w_full),
        .o_valid     (w_valid),
        .o_head      (w_head)
    );

    ufh_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_valid),
        .i_head      (w_head),
        .i_eff_count (w_eff),
        .o_pop       (w_pop),
        .o_clearing  (w_clearing),
        .o_done      (o_done),
        .o_res       (w_res)
    );

    assign o_first_root     = w_res.first_root;
    assign o_second_root    = w_res.second_root;
    assign o_already_joined = w_res.already_joined;
    assign o_new_root       = w_res.new_root;
    assign o_merged_size    = w_res.merged_size;
    assign o_union_total    = w_res.union_total;
    assign o_request_total  = w_res.request_total;
    assign o_all_joined     = w_res.all_joined;
    assign o_bad_index      = w_res.bad_index;

endmodule
